// ===== rtl/qtrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtrm_pkg
// shared types and constants for the quaternion to rotation matrix pipeline
// ----------------------------------------------------------------------------
package qtrm_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int FRACTION_BITS_DEF   = 14;
   localparam int FIELD_WIDTH         = 16;
   localparam int MAT_WIDTH           = 16;
   localparam int ENTRIES             = 9;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] comp_x;
      logic signed [FIELD_WIDTH-1:0] comp_y;
      logic signed [FIELD_WIDTH-1:0] comp_z;
      logic signed [FIELD_WIDTH-1:0] comp_w;
   } req_word_type;

   typedef struct packed {
      logic signed [MAT_WIDTH-1:0] m00;
      logic signed [MAT_WIDTH-1:0] m01;
      logic signed [MAT_WIDTH-1:0] m02;
      logic signed [MAT_WIDTH-1:0] m10;
      logic signed [MAT_WIDTH-1:0] m11;
      logic signed [MAT_WIDTH-1:0] m12;
      logic signed [MAT_WIDTH-1:0] m20;
      logic signed [MAT_WIDTH-1:0] m21;
      logic signed [MAT_WIDTH-1:0] m22;
      logic                        zero_norm;
   } rsp_word_type;

   // control that rides along each divider cell
   typedef struct packed {
      logic               valid;
      logic               zero;
      logic [ENTRIES-1:0] sign;
   } ctl_type;

endpackage
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// quaternion to 3x3 rotation matrix in Q1.FRACTION_BITS, normalized by the
// squared norm through a row of division cells
//
//   channel  ports                        direction
//   request  start, busy, req_word        in, accepted at start & !busy
//   response rsp_strobe, rsp_word         out, one cycle per word
//
// one word per cycle; busy stays low
// the pipeline has four front stages, FRACTION_BITS + 1 division cells
// and one output stage
// synchronous reset empties the pipeline; the receiver cannot stall
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix import qtrm_pkg::*; #(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int DW  = 2*COMPONENT_WIDTH+1;
   localparam int QW  = FRACTION_BITS+2;
   localparam int NC  = FRACTION_BITS+1;
   localparam int LAT = FRACTION_BITS+6;

   ctl_type                    ctl_c [0:NC];
   logic [DW-1:0]              d_c   [0:NC];
   logic [ENTRIES-1:0][DW-1:0] r_c   [0:NC];
   logic [ENTRIES-1:0][QW-1:0] q_c   [0:NC];

   assign busy = 1'b0;

   qtrm_front #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (start && !busy),
      .req_word(req_word),
      .ctl_ff  (ctl_c[0]),
      .d_ff    (d_c[0]),
      .r_ff    (r_c[0]),
      .q_ff    (q_c[0])
   );

   for (genvar k = 0; k < NC; k++) begin : g_cell
      qtrm_cell #(
         .COMPONENT_WIDTH(COMPONENT_WIDTH),
         .FRACTION_BITS  (FRACTION_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl_in(ctl_c[k]),
         .d_in  (d_c[k]),
         .r_in  (r_c[k]),
         .q_in  (q_c[k]),
         .ctl_ff(ctl_c[k+1]),
         .d_ff  (d_c[k+1]),
         .r_ff  (r_c[k+1]),
         .q_ff  (q_c[k+1])
      );
   end

   qtrm_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_c[NC]),
      .q_in      (q_c[NC]),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("response word without matching request");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.zero_norm |->
         rsp_word.m01 == '0 && rsp_word.m12 == '0 && rsp_word.m20 == '0 &&
         rsp_word.m00 == rsp_word.m11 && rsp_word.m11 == rsp_word.m22)
      else $error("zero norm word is not the identity");
`endif

endmodule
`default_nettype wire

// ===== rtl/qtrm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtrm_front
// magnitudes, pair products, numerators and squared norm, first quotient bit
// ----------------------------------------------------------------------------
module qtrm_front import qtrm_pkg::*; #(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         take,
   input  req_word_type                                req_word,
   output ctl_type                                     ctl_ff,
   output logic [2*COMPONENT_WIDTH:0]                  d_ff,
   output logic [ENTRIES-1:0][2*COMPONENT_WIDTH:0]     r_ff,
   output logic [ENTRIES-1:0][FRACTION_BITS+1:0]       q_ff
);

   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2*CW;
   localparam int DW = 2*CW+1;
   localparam int QW = FRACTION_BITS+2;

   logic [3:0][CW-1:0] u;
   logic [3:0][CW-1:0] mag_in;
   logic [3:0][CW-1:0] mag_ff;
   logic [3:0]         neg_ff;
   logic               va_ff;

   logic [3:0][PW-1:0] sq_ff;
   logic [5:0][PW-1:0] xp_ff;
   logic [5:0]         xs_ff;
   logic               vb_ff;

   logic [ENTRIES-1:0][DW-1:0] n_in;
   logic [ENTRIES-1:0]         s_in;
   logic [ENTRIES-1:0][DW-1:0] n_ff;
   logic [ENTRIES-1:0]         s_ff;
   logic [DW-1:0]              dc_ff;
   logic                       vc_ff;

   function automatic logic [DW:0] smadd(input logic s1, input logic [PW-1:0] m1,
                                         input logic s2, input logic [PW-1:0] m2);
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic [DW-1:0] m;
      logic          s;
      a = DW'(m1);
      b = DW'(m2);
      if (s1 == s2) begin
         s = s1;
         m = a + b;
      end else if (a >= b) begin
         s = s1;
         m = a - b;
      end else begin
         s = s2;
         m = b - a;
      end
      return {s, m[DW-2:0], 1'b0};
   endfunction

   function automatic logic [DW:0] dsub(input logic [PW-1:0] a1, input logic [PW-1:0] a2,
                                        input logic [PW-1:0] b1, input logic [PW-1:0] b2);
      logic [DW-1:0] pa;
      logic [DW-1:0] pb;
      pa = DW'(a1) + DW'(a2);
      pb = DW'(b1) + DW'(b2);
      if (pa >= pb) begin
         return {1'b0, pa - pb};
      end
      return {1'b1, pb - pa};
   endfunction

   // x y z w magnitudes
   always_comb begin
      u[0] = CW'($unsigned(req_word.comp_x));
      u[1] = CW'($unsigned(req_word.comp_y));
      u[2] = CW'($unsigned(req_word.comp_z));
      u[3] = CW'($unsigned(req_word.comp_w));
      for (int i = 0; i < 4; i++) begin
         mag_in[i] = u[i][CW-1] ? CW'(-u[i]) : u[i];
      end
   end

   always_comb begin
      {s_in[0], n_in[0]} = dsub(sq_ff[0], sq_ff[3], sq_ff[1], sq_ff[2]);
      {s_in[1], n_in[1]} = smadd(xs_ff[0], xp_ff[0], ~xs_ff[5], xp_ff[5]);
      {s_in[2], n_in[2]} = smadd(xs_ff[1], xp_ff[1],  xs_ff[4], xp_ff[4]);
      {s_in[3], n_in[3]} = smadd(xs_ff[0], xp_ff[0],  xs_ff[5], xp_ff[5]);
      {s_in[4], n_in[4]} = dsub(sq_ff[1], sq_ff[3], sq_ff[0], sq_ff[2]);
      {s_in[5], n_in[5]} = smadd(xs_ff[3], xp_ff[3], ~xs_ff[2], xp_ff[2]);
      {s_in[6], n_in[6]} = smadd(xs_ff[1], xp_ff[1], ~xs_ff[4], xp_ff[4]);
      {s_in[7], n_in[7]} = smadd(xs_ff[3], xp_ff[3],  xs_ff[2], xp_ff[2]);
      {s_in[8], n_in[8]} = dsub(sq_ff[2], sq_ff[3], sq_ff[0], sq_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff      <= 1'b0;
         vb_ff      <= 1'b0;
         vc_ff      <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         va_ff      <= take;
         vb_ff      <= va_ff;
         vc_ff      <= vb_ff;
         ctl_ff.valid <= vc_ff;
      end
      mag_ff <= mag_in;
      neg_ff <= {u[3][CW-1], u[2][CW-1], u[1][CW-1], u[0][CW-1]};
      for (int i = 0; i < 4; i++) begin
         sq_ff[i] <= mag_ff[i] * mag_ff[i];
      end
      // xy xz xw yz yw zw
      xp_ff[0] <= mag_ff[0] * mag_ff[1];
      xp_ff[1] <= mag_ff[0] * mag_ff[2];
      xp_ff[2] <= mag_ff[0] * mag_ff[3];
      xp_ff[3] <= mag_ff[1] * mag_ff[2];
      xp_ff[4] <= mag_ff[1] * mag_ff[3];
      xp_ff[5] <= mag_ff[2] * mag_ff[3];
      xs_ff    <= {neg_ff[2] ^ neg_ff[3], neg_ff[1] ^ neg_ff[3], neg_ff[1] ^ neg_ff[2],
                   neg_ff[0] ^ neg_ff[3], neg_ff[0] ^ neg_ff[2], neg_ff[0] ^ neg_ff[1]};
      n_ff  <= n_in;
      s_ff  <= s_in;
      dc_ff <= DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]) + DW'(sq_ff[3]);
      d_ff        <= dc_ff;
      ctl_ff.zero <= (dc_ff == '0);
      ctl_ff.sign <= s_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         r_ff[i] <= (n_ff[i] >= dc_ff) ? n_ff[i] - dc_ff : n_ff[i];
         q_ff[i] <= QW'(n_ff[i] >= dc_ff);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/qtrm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtrm_cell
// one restoring division step for all nine entries
// ----------------------------------------------------------------------------
module qtrm_cell import qtrm_pkg::*; #(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  ctl_type                                    ctl_in,
   input  wire  [2*COMPONENT_WIDTH:0]                 d_in,
   input  wire  [ENTRIES-1:0][2*COMPONENT_WIDTH:0]    r_in,
   input  wire  [ENTRIES-1:0][FRACTION_BITS+1:0]      q_in,
   output ctl_type                                    ctl_ff,
   output logic [2*COMPONENT_WIDTH:0]                 d_ff,
   output logic [ENTRIES-1:0][2*COMPONENT_WIDTH:0]    r_ff,
   output logic [ENTRIES-1:0][FRACTION_BITS+1:0]      q_ff
);

   localparam int DW = 2*COMPONENT_WIDTH+1;
   localparam int QW = FRACTION_BITS+2;

   logic [ENTRIES-1:0][DW:0]   t;
   logic [ENTRIES-1:0][DW:0]   diff;
   logic [ENTRIES-1:0]         ge;
   logic [ENTRIES-1:0][DW-1:0] r_in_next;
   logic [ENTRIES-1:0][QW-1:0] q_in_next;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         t[i]         = {r_in[i], 1'b0};
         ge[i]        = t[i] >= {1'b0, d_in};
         diff[i]      = t[i] - {1'b0, d_in};
         r_in_next[i] = ge[i] ? diff[i][DW-1:0] : t[i][DW-1:0];
         q_in_next[i] = {q_in[i][QW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.zero <= ctl_in.zero;
      ctl_ff.sign <= ctl_in.sign;
      d_ff <= d_in;
      r_ff <= r_in_next;
      q_ff <= q_in_next;
   end

endmodule
`default_nettype wire

// ===== rtl/qtrm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtrm_back
// rounding, sign, saturation and identity substitution for a zero norm
// ----------------------------------------------------------------------------
module qtrm_back import qtrm_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  ctl_type                               ctl_in,
   input  wire  [ENTRIES-1:0][FRACTION_BITS+1:0] q_in,
   output logic                                  rsp_strobe,
   output rsp_word_type                          rsp_word
);

   localparam int QW = FRACTION_BITS+2;
   localparam int SW = (QW > MAT_WIDTH+1) ? QW : MAT_WIDTH+1;
   localparam logic [SW-1:0] POS_MAX = SW'((1 << (MAT_WIDTH-1)) - 1);
   localparam logic [SW-1:0] NEG_MAX = SW'(1 << (MAT_WIDTH-1));
   localparam logic [SW-1:0] ONE_RAW = SW'(1) << FRACTION_BITS;
   localparam logic [SW-1:0] ONE_SAT = (ONE_RAW > POS_MAX) ? POS_MAX : ONE_RAW;

   logic [ENTRIES-1:0][QW:0]          qp;
   logic [ENTRIES-1:0][SW-1:0]        qe;
   logic [ENTRIES-1:0]                sg;
   logic [ENTRIES-1:0][MAT_WIDTH:0]   mg;
   logic [ENTRIES-1:0][MAT_WIDTH:0]   sv;
   logic [ENTRIES-1:0][MAT_WIDTH-1:0] m_in;
   logic                              rsp_strobe_ff;
   rsp_word_type                      rsp_word_ff;
   rsp_word_type                      rsp_word_in;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         qp[i] = ({1'b0, q_in[i]} + (QW+1)'(1)) >> 1;
         qe[i] = SW'(qp[i]);
         sg[i] = ctl_in.sign[i] && (qe[i] != '0);
         if (!sg[i] && qe[i] > POS_MAX) begin
            mg[i] = (MAT_WIDTH+1)'(POS_MAX);
         end else if (sg[i] && qe[i] > NEG_MAX) begin
            mg[i] = (MAT_WIDTH+1)'(NEG_MAX);
         end else begin
            mg[i] = qe[i][MAT_WIDTH:0];
         end
         sv[i] = sg[i] ? (MAT_WIDTH+1)'(-mg[i]) : mg[i];
         if (ctl_in.zero) begin
            m_in[i] = (i % 4 == 0) ? ONE_SAT[MAT_WIDTH-1:0] : '0;
         end else begin
            m_in[i] = sv[i][MAT_WIDTH-1:0];
         end
      end
      rsp_word_in.m00       = m_in[0];
      rsp_word_in.m01       = m_in[1];
      rsp_word_in.m02       = m_in[2];
      rsp_word_in.m10       = m_in[3];
      rsp_word_in.m11       = m_in[4];
      rsp_word_in.m12       = m_in[5];
      rsp_word_in.m20       = m_in[6];
      rsp_word_in.m21       = m_in[7];
      rsp_word_in.m22       = m_in[8];
      rsp_word_in.zero_norm = ctl_in.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_in.valid;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire
